// ===== sv/sts_pkg.sv =====
// Shared constants and widths for the series sine block.
package sts_pkg;

  // Fixed-point format of the angle, the sine and the cosine.
  localparam int FRAC_BITS  = 28;
  localparam int ANGLE_W    = 32;
  localparam int SINE_W     = FRAC_BITS + 2;
  localparam int COS_W      = FRAC_BITS + 1;
  localparam int TOL_W      = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

  // Default number of series terms.
  localparam int TERMS_DEF  = 32;

  // Term magnitudes saturate at 2^62, so they fit in 63 bits.
  localparam int MAG_W      = 63;
  localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

  // Stream widths: tdata padded to whole bytes.
  localparam int IN_DATA_W  = ((ANGLE_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = SINE_W + COS_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Multiplier and accumulator.
  localparam int MUL_W      = 32;
  localparam int ACC_W      = MAG_W + ANGLE_W;

  // Divider: quotient bits per cycle and padded dividend width.
  localparam int DIV_BITS   = 8;
  localparam int QW         = ((MAG_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_CYC    = QW / DIV_BITS;

  // Square root: one result bit per cycle.
  localparam int SQRT_CYC   = FRAC_BITS + 1;
  localparam int RAD_W      = 2 * (FRAC_BITS + 1);
  localparam int SREM_W     = FRAC_BITS + 2;

  localparam int CNT_MAX    = (SQRT_CYC > DIV_CYC) ? SQRT_CYC : DIV_CYC;
  localparam int CNT_W      = $clog2(CNT_MAX);

endpackage

// ===== sv/sine_taylor_series.sv =====
// Series sine with cosine magnitude and near-equality flag, one shared multiplier.
//
//   channel  | direction | ports                                   | transaction
//   ---------+-----------+-----------------------------------------+--------------------------
//   in       | slave     | in_tvalid, in_tready, in_tdata[31:0]    | one angle, Q4.28 unsigned
//   out      | master    | out_tvalid, out_tready, out_tdata[63:0] | sine, cosine, flag
//   cfg      | write     | cfg_wr_en, cfg_wr_data[7:0]             | equal tolerance in LSBs
//
// Each series term costs two products of a 63-bit magnitude by the 32-bit
// angle, each done in two halves on the single 32x32 multiplier plus a
// saturation step, then the 8-bit-per-cycle divider and an add into the
// running sum. The square root then resolves one bit per cycle.
// Reset is synchronous and active low; it clears the sequencer, the output
// valid and sets the tolerance to 3. The input side is ready only while the
// sequencer is idle. A finished result waits in the output register, so a
// stalled output does not hold off the next angle; only a second result
// waiting behind the first one stalls the sequencer in its final state.
module sine_taylor_series
  import sts_pkg::*;
#(
  parameter int TERMS = TERMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. tdata: angle [31:0].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream. tdata: sine_value [29:0] (signed), cosine_magnitude [58:30],
  // near_equal [59], zero padding [63:60].
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration: equal_tolerance.
  input  logic                  cfg_wr_en,
  input  logic [TOL_W-1:0]      cfg_wr_data
);

  // Term index and divisor widths follow from the term count.
  localparam int KW    = $clog2(TERMS);
  localparam int D_MAX = 2 * (TERMS - 1) * (2 * TERMS - 1);
  localparam int DW    = $clog2(D_MAX + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MLO   = 4'd1;
  localparam logic [3:0] ST_MHI   = 4'd2;
  localparam logic [3:0] ST_MSAT  = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_ADD   = 4'd5;
  localparam logic [3:0] ST_CLAMP = 4'd6;
  localparam logic [3:0] ST_SQ    = 4'd7;
  localparam logic [3:0] ST_SQRT  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  localparam logic signed [64:0] SUM_CAP = 65'sd1 <<< (MAG_W - 1);
  localparam logic signed [63:0] ONE_S   = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0]        ONE2    = 64'd1 << (2 * FRAC_BITS);

  // Control state.
  logic [3:0]       state_r, state_nxt;
  logic             pass_r, pass_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  // Datapath registers.
  logic [ANGLE_W-1:0]     x_r, x_nxt;
  logic [MAG_W-1:0]       m_r, m_nxt;
  logic signed [63:0]     sum_r, sum_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [QW-1:0]          q_r, q_nxt;
  logic [DW-1:0]          rem_r, rem_nxt;
  logic signed [SINE_W-1:0] sine_r, sine_nxt;
  logic [COS_W-1:0]       smag_r, smag_nxt;
  logic [RAD_W-1:0]       v_r, v_nxt;
  logic [SREM_W-1:0]      srem_r, srem_nxt;
  logic [COS_W-1:0]       root_r, root_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  // The shared multiplier.
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;

  always_comb begin
    case (state_r)
      ST_MHI: begin
        mul_a = MUL_W'(m_r[MAG_W-1:MUL_W]);
        mul_b = x_r;
      end
      ST_SQ: begin
        mul_a = MUL_W'(smag_r);
        mul_b = MUL_W'(smag_r);
      end
      default: begin
        mul_a = m_r[MUL_W-1:0];
        mul_b = x_r;
      end
    endcase
  end

  assign mul_p = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

  // Saturated scaled product from the accumulator.
  logic [ACC_W-FRAC_BITS-1:0] acc_shift;
  logic [MAG_W-1:0]           m_sat;

  assign acc_shift = acc_r[ACC_W-1:FRAC_BITS];
  assign m_sat = (acc_shift > (ACC_W-FRAC_BITS)'(MAG_CAP)) ? MAG_CAP : acc_shift[MAG_W-1:0];

  // Divider: DIV_BITS restoring steps per cycle on a narrow remainder.
  logic [QW-1:0] dq;
  logic [DW-1:0] drem;

  always_comb begin
    logic [DW:0] drem2;
    logic        ge;
    dq   = q_r;
    drem = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      drem2 = {drem, dq[QW-1]};
      ge    = (drem2 >= {1'b0, d_r});
      drem  = ge ? DW'(drem2 - {1'b0, d_r}) : DW'(drem2);
      dq    = {dq[QW-2:0], ge};
    end
  end

  // Running sum with saturation at plus or minus 2^62.
  logic signed [64:0] sum_wide;
  logic signed [63:0] sum_sat;

  assign sum_wide = k_r[0] ? ({sum_r[63], sum_r} - $signed({2'b00, q_r[MAG_W-1:0]}))
                           : ({sum_r[63], sum_r} + $signed({2'b00, q_r[MAG_W-1:0]}));
  assign sum_sat  = (sum_wide > SUM_CAP)  ? SUM_CAP[63:0] :
                    (sum_wide < -SUM_CAP) ? 64'(-SUM_CAP) : sum_wide[63:0];

  // Final clamp of the sum to plus or minus one.
  logic signed [63:0] sum_clamp;

  assign sum_clamp = (sum_r > ONE_S) ? ONE_S : (sum_r < -ONE_S) ? -ONE_S : sum_r;

  // Square-root step.
  logic [SREM_W+1:0] srem2, strial;
  logic              sge;

  assign srem2  = {srem_r, v_r[RAD_W-1:RAD_W-2]};
  assign strial = {1'b0, root_r, 2'b01};
  assign sge    = (srem2 >= strial);

  // Result fields and the near-equality flag.
  logic signed [SINE_W:0] diff, diff_abs;
  logic                   near_eq;

  assign diff     = $signed({2'b00, root_r}) - $signed({sine_r[SINE_W-1], sine_r});
  assign diff_abs = diff[SINE_W] ? -diff : diff;
  assign near_eq  = ($unsigned(diff_abs) <= (SINE_W+1)'(tol_r));

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    tol_nxt        = cfg_wr_en ? cfg_wr_data : tol_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    x_nxt          = x_r;
    m_nxt          = m_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    d_nxt          = d_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    sine_nxt       = sine_r;
    smag_nxt       = smag_r;
    v_nxt          = v_r;
    srem_nxt       = srem_r;
    root_nxt       = root_r;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // Term 0 is the angle itself; it is always below the cap.
          x_nxt     = in_tdata[ANGLE_W-1:0];
          m_nxt     = MAG_W'(in_tdata[ANGLE_W-1:0]);
          sum_nxt   = 64'(in_tdata[ANGLE_W-1:0]);
          k_nxt     = KW'(1);
          d_nxt     = DW'(6);
          pass_nxt  = 1'b0;
          state_nxt = ST_MLO;
        end
      end
      ST_MLO: begin
        acc_nxt   = ACC_W'(mul_p);
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        acc_nxt   = acc_r + {mul_p[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
        state_nxt = ST_MSAT;
      end
      ST_MSAT: begin
        if (!pass_r) begin
          m_nxt     = m_sat;
          pass_nxt  = 1'b1;
          state_nxt = ST_MLO;
        end else begin
          q_nxt     = QW'(m_sat);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        q_nxt   = dq;
        rem_nxt = drem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_CYC - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        // Odd terms subtract, even terms add.
        m_nxt    = q_r[MAG_W-1:0];
        sum_nxt  = sum_sat;
        pass_nxt = 1'b0;
        if (k_r == KW'(TERMS - 1)) begin
          state_nxt = ST_CLAMP;
        end else begin
          // (2k+2)(2k+3) - (2k)(2k+1) = 8k + 6
          d_nxt     = d_r + (DW'(k_r) << 3) + DW'(6);
          k_nxt     = k_r + KW'(1);
          state_nxt = ST_MLO;
        end
      end
      ST_CLAMP: begin
        sine_nxt  = SINE_W'(sum_clamp);
        smag_nxt  = sum_clamp[63] ? COS_W'(-sum_clamp) : COS_W'(sum_clamp);
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        v_nxt     = (mul_p > ONE2) ? '0 : RAD_W'(ONE2 - mul_p);
        srem_nxt  = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        srem_nxt = sge ? SREM_W'(srem2 - strial) : SREM_W'(srem2);
        root_nxt = {root_r[COS_W-2:0], sge};
        v_nxt    = v_r << 2;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SQRT_CYC - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = OUT_DATA_W'({near_eq, root_r, sine_r});
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pass_r       <= 1'b0;
      k_r          <= '0;
      cnt_r        <= '0;
      tol_r        <= TOL_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pass_r       <= pass_nxt;
      k_r          <= k_nxt;
      cnt_r        <= cnt_nxt;
      tol_r        <= tol_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    m_r         <= m_nxt;
    sum_r       <= sum_nxt;
    acc_r       <= acc_nxt;
    d_r         <= d_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    sine_r      <= sine_nxt;
    smag_r      <= smag_nxt;
    v_r         <= v_nxt;
    srem_r      <= srem_nxt;
    root_r      <= root_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // An accepted angle always starts the first product.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_MLO))
    else $error("accepted angle did not start the series");

  // The divider remainder stays below the divisor.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

  // The term index never runs past the last term.
  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> (k_r <= KW'(TERMS - 1) && k_r != '0))
    else $error("term index out of range");

  // A delivered sine lies within plus or minus one.
  a_sine: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[SINE_W-1:0]) <= $signed(ONE_S[SINE_W-1:0]) &&
                    $signed(out_tdata[SINE_W-1:0]) >= -$signed(ONE_S[SINE_W-1:0])))
    else $error("sine outside plus or minus one");

  // A delivered cosine magnitude is at most one.
  a_cos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[SINE_W+COS_W-1:SINE_W] <= COS_W'(ONE_S)))
    else $error("cosine magnitude above one");

endmodule

// ===== dv/sts_result_checker.sv =====
// Checker for the series sine block: predicts every result and compares it field by field.
module sts_result_checker
  import sts_pkg::*;
#(
  parameter int TERMS = TERMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [TOL_W-1:0]      cfg_wr_data,
  output int unsigned           error_count,
  output int unsigned           results_owed
);

  // Same field order as out_tdata, sine in the lowest bits.
  typedef struct packed {
    logic             near_eq;
    logic [COS_W-1:0] cosine;
    logic [SINE_W-1:0] sine;
  } sine_result_t;

  localparam logic signed [65:0] SUM_CAP = 66'sd4611686018427387904;
  localparam logic signed [65:0] ONE_Q   = 66'sd1 <<< FRAC_BITS;

  sine_result_t     expected_q[$];
  logic [TOL_W-1:0] tol_cur;
  int unsigned      shown;

  initial begin
    error_count  = 0;
    results_owed = 0;
    shown        = 0;
    tol_cur      = TOL_RESET;
  end

  // (a * x) >> FRAC_BITS with the product held in full, capped at 2^62.
  function automatic logic [MAG_W-1:0] scale_mul(input logic [MAG_W-1:0] a,
                                                 input logic [ANGLE_W-1:0] x);
    logic [127:0] p;
    p = ({65'd0, a} * {96'd0, x}) >> FRAC_BITS;
    if (p > {65'd0, MAG_CAP})
      return MAG_CAP;
    return p[MAG_W-1:0];
  endfunction

  function automatic sine_result_t predict_sine(input logic [ANGLE_W-1:0] x,
                                                input logic [TOL_W-1:0] tol);
    sine_result_t        r;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    denom;
    logic signed [65:0]  sum;
    logic signed [65:0]  abs_sum;
    logic                neg;
    logic [FRAC_BITS:0]  smag;
    logic [RAD_W-1:0]    one_sq;
    logic [RAD_W-1:0]    sq;
    logic [RAD_W-1:0]    rad;
    logic [FRAC_BITS+1:0] root;
    logic [FRAC_BITS+1:0] trial;
    logic signed [33:0]  diff;
    mag = MAG_W'(x);
    sum = $signed({34'd0, x});
    neg = 1'b0;
    // Each term is the previous one times x*x over (2k)(2k+1), signs alternating.
    for (int k = 1; k < TERMS; k++) begin
      denom = MAG_W'((2 * k) * (2 * k + 1));
      mag   = scale_mul(mag, x);
      mag   = scale_mul(mag, x);
      mag   = mag / denom;
      neg   = !neg;
      sum   = neg ? sum - $signed({3'b000, mag}) : sum + $signed({3'b000, mag});
      if (sum > SUM_CAP)  sum = SUM_CAP;
      if (sum < -SUM_CAP) sum = -SUM_CAP;
    end
    if (sum > ONE_Q)  sum = ONE_Q;
    if (sum < -ONE_Q) sum = -ONE_Q;

    abs_sum = (sum < 0) ? -sum : sum;
    smag    = abs_sum[FRAC_BITS:0];
    one_sq  = '0;
    one_sq[2*FRAC_BITS] = 1'b1;
    sq      = RAD_W'(smag) * RAD_W'(smag);
    rad     = (sq > one_sq) ? '0 : one_sq - sq;

    // Floor square root, one bit at a time from the top.
    root = '0;
    for (int b = FRAC_BITS + 1; b >= 0; b--) begin
      trial = root | ((FRAC_BITS+2)'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(rad))
        root = trial;
    end

    diff = $signed({4'b0000, root}) - $signed(sum[33:0]);
    if (diff < 0) diff = -diff;

    r.sine    = sum[SINE_W-1:0];
    r.cosine  = root[COS_W-1:0];
    r.near_eq = (diff <= $signed({26'd0, tol}));
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sine_result_t got;
    sine_result_t want;
    if (!rst_n) begin
      tol_cur = TOL_RESET;
    end else begin
      if (cfg_wr_en)
        tol_cur = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_sine(in_tdata[ANGLE_W-1:0], tol_cur));
        results_owed++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_FLD_W-1:0];
        if (expected_q.size() == 0) begin
          error_count++;
          if (shown < 60) begin
            shown++;
            $display("%0t: result with no angle outstanding, expected none, got sine %0d cos %0d flag %0b",
                     $time, $signed(got.sine), got.cosine, got.near_eq);
          end
        end else begin
          want = expected_q.pop_front();
          results_owed--;
          if (got != want) begin
            error_count++;
            if (shown < 60) begin
              shown++;
              if (got.sine != want.sine)
                $display("%0t: sine_value mismatch, expected %0d, got %0d",
                         $time, $signed(want.sine), $signed(got.sine));
              if (got.cosine != want.cosine)
                $display("%0t: cosine_magnitude mismatch, expected %0d, got %0d",
                         $time, want.cosine, got.cosine);
              if (got.near_eq != want.near_eq)
                $display("%0t: near_equal mismatch, expected %0b, got %0b",
                         $time, want.near_eq, got.near_eq);
            end
          end
        end
      end
    end
  end

endmodule

// ===== dv/sine_taylor_series_tb.sv =====
// Testbench top for the series sine block: stimulus, idling and the final verdict.
module sine_taylor_series_tb;
  import sts_pkg::*;

  // Angles of interest in Q4.28. The crossings are where the sine equals the
  // cosine magnitude with a positive sine (pi/4 and 3pi/4 plus whole turns);
  // the peaks are odd multiples of pi/2, where the sum may need saturation.
  localparam logic [ANGLE_W-1:0] PI_Q      = 32'd843314857;
  localparam logic [ANGLE_W-1:0] ONE_RAD_Q = 32'd268435456;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tready  = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [TOL_W-1:0]      cfg_wr_data = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  int unsigned           error_count;
  int unsigned           results_owed;

  // Idle counters of the two sides. A nonzero steady count means a stretch
  // with no idling at all on that side.
  int unsigned in_steady    = 0;
  int unsigned ready_hold   = 0;
  int unsigned ready_steady = 0;

  always #5 clk = ~clk;

  sine_taylor_series i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  sts_result_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .error_count  (error_count),
    .results_owed (results_owed)
  );

  // Safety net. The timeout allows for the slowest legal pattern of gaps
  // and stalls.
  initial begin
    #50_000_000;
    $display("sine_taylor_series_tb: errors");
    $finish;
  end

  // Idle length: mostly none or short, now and then long. The rare longest
  // tier can exceed the block's latency, so gaps also land while it sits idle.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 40);
    return $urandom_range(300, 650);
  endfunction

  function automatic logic [ANGLE_W-1:0] landmark(input int unsigned idx);
    case (idx)
      0:       return 32'd210828714;   // pi/4
      1:       return 32'd632486143;   // 3pi/4
      2:       return 32'd1897458427;  // 9pi/4
      3:       return 32'd2319115855;  // 11pi/4
      4:       return 32'd3584088140;  // 17pi/4
      5:       return 32'd4005745568;  // 19pi/4
      6:       return 32'd421657428;   // pi/2
      7:       return 32'd1264972285;  // 3pi/2
      8:       return 32'd2108287141;  // 5pi/2
      9:       return 32'd2951601998;  // 7pi/2
      default: return 32'd3794916854;  // 9pi/2
    endcase
  endfunction

  // Random angles lean toward the places where the flag and the saturation
  // can trip, with some near zero and the rest spread over the whole 32-bit range.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 20)
      return landmark($urandom_range(0, 5)) + $urandom_range(0, 40) - 32'd20;
    if (sel < 32)
      return landmark($urandom_range(0, 5)) + $urandom_range(0, 800) - 32'd400;
    if (sel < 45)
      return landmark($urandom_range(6, 10)) + $urandom_range(0, 4000) - 32'd2000;
    if (sel < 55)
      return $urandom_range(0, 32'h0010_0000);
    return $urandom();
  endfunction

  // Extremes of the angle, bit patterns and the named points of the curve.
  function automatic logic [ANGLE_W-1:0] directed_angle(input int unsigned idx);
    case (idx)
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'hAAAA_AAAA;
      5:       return 32'h5555_5555;
      6:       return ONE_RAD_Q;
      7:       return ONE_RAD_Q - 32'd1;
      8:       return landmark(0);
      9:       return landmark(0) + 32'd1;
      10:      return landmark(1);
      11:      return landmark(6) - 32'd1;
      12:      return landmark(6);
      13:      return landmark(6) + 32'd1;
      14:      return PI_Q;
      15:      return landmark(7);
      16:      return 32'd2 * PI_Q;
      17:      return 32'd5 * PI_Q;
      18:      return landmark(4);
      default: return landmark(10);
    endcase
  endfunction

  // One input transaction. Valid stays high from one angle to the next when
  // no gap is drawn, so it is never dropped and raised in the same step.
  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    int unsigned gap;
    if (in_steady != 0) begin
      gap = 0;
      in_steady--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 29) == 0)
        in_steady = $urandom_range(10, 40);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= angle;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every predicted result has come back. The
  // count is read at the falling edge, when the checker's update has settled.
  task automatic wait_results_in();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // Only called with the block idle, so the new tolerance applies to every
  // angle that follows and to none before.
  task automatic write_tolerance(input logic [TOL_W-1:0] tol);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tol;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Result-side back-pressure: short stalls, a few long ones, and steady
  // stretches. Long stalls let a second result queue behind the first.
  always @(posedge clk) begin : ready_pattern
    int unsigned roll;
    if (ready_hold != 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (ready_steady != 0) begin
      out_tready   <= 1'b1;
      ready_steady <= ready_steady - 1;
    end else begin
      roll = $urandom_range(0, 999);
      if (roll < 5) begin
        out_tready   <= 1'b1;
        ready_steady <= $urandom_range(500, 3000);
      end else if (roll < 80) begin
        out_tready <= 1'b0;
        ready_hold <= idle_len();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [TOL_W-1:0] tol_plan;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed angles run with the tolerance left at its reset value.
    for (int i = 0; i < 20; i++)
      send_angle(directed_angle(i));

    // Random phases, each under its own tolerance, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      wait_results_in();
      case (phase)
        0:       tol_plan = 8'd255;
        1:       tol_plan = 8'd0;
        2:       tol_plan = TOL_W'($urandom_range(1, 254));
        3:       tol_plan = TOL_W'($urandom_range(0, 255));
        default: tol_plan = 8'd1;
      endcase
      write_tolerance(tol_plan);
      for (int n = 0; n < 106; n++) begin
        // Occasionally let the block drain completely mid-phase.
        if ($urandom_range(0, 79) == 0)
          wait_results_in();
        send_angle(pick_angle());
      end
    end

    wait_results_in();
    // Keep the clock running to catch any stray result.
    repeat (600) @(posedge clk);
    if (error_count == 0 && results_owed == 0)
      $display("sine_taylor_series_tb: clean");
    else
      $display("sine_taylor_series_tb: errors");
    $finish;
  end

endmodule
